@@ hw/rtl/elf_stream_loader_macros.svh @@
// Assertion macros shared by the loader RTL.
// Each macro expands to one labeled concurrent assertion on clk_i/rst_ni.
`ifndef ELF_STREAM_LOADER_MACROS_SVH
`define ELF_STREAM_LOADER_MACROS_SVH

// Same-cycle implication
`define ESL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("loader assertion failed");

// Next-cycle implication
`define ESL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("loader assertion failed");

`endif

@@ hw/rtl/esl_pkg.sv @@
// Shared types and constants of the streaming ELF loader.
// Used by esl_ctrl, esl_dp and elf_stream_loader; no dependencies.
package esl_pkg;

  localparam int unsigned MAX_SEG = 8;
  localparam int unsigned SEG_IW  = (MAX_SEG > 1) ? $clog2(MAX_SEG) : 1;
  localparam int unsigned CUR_W   = $clog2(MAX_SEG + 1);

  localparam logic [31:0] HDR_LAST_POS = 32'd51;
  localparam logic [31:0] PH_USED_LEN  = 32'd24;

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_MAGIC  = 2'd0,
    ERR_COUNT  = 2'd1,
    ERR_BEHIND = 2'd2,
    ERR_NONE   = 2'd3
  } err_e;

  typedef enum logic [8:0] {
    ST_HDR   = 9'b000000001,
    ST_FIN   = 9'b000000010,
    ST_TBL   = 9'b000000100,
    ST_DISP  = 9'b000001000,
    ST_SKIP  = 9'b000010000,
    ST_LOAD  = 9'b000100000,
    ST_LFILL = 9'b001000000,
    ST_DONE  = 9'b010000000,
    ST_ERR   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic  hdr_byte;
    logic  tbl_byte;
    logic  skip_byte;
    logic  load_byte;
    logic  init_tbl;
    logic  seg_inc;
    logic  bis_clr;
    logic  push;
    kind_e push_kind;
    err_e  push_err;
    logic  flush;
  } cmd_t;

  typedef struct packed {
    logic magic_ok;
    logic hdr_last;
    logic count_big;
    logic tsize_zero;
    logic cur_end;
    logic cur_is_load;
    logic off_lt;
    logic off_gt;
    logic fsz_zero;
    logic tbl_end;
    logic skip_hit;
    logic load_end;
    logic pend_v;
    logic out_free;
  } sts_t;

  // Expected ELF magic byte at file offset 0..3
  function automatic logic [7:0] magic_byte(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0:    r = 8'h7F;
      2'd1:    r = 8'h45;
      2'd2:    r = 8'h4C;
      default: r = 8'h46;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/esl_dp.sv @@
// Datapath of the ELF loader: header fields, segment table, counters, result regs.
// Depends on esl_pkg and elf_stream_loader_macros.svh.
`include "elf_stream_loader_macros.svh"
module esl_dp
  import esl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_tready_i,
  output logic        out_valid_o,
  output kind_e       out_kind_o,
  output logic [31:0] out_addr_o,
  output logic [7:0]  out_data_o,
  output logic [31:0] out_len_o,
  output logic [1:0]  out_err_o,
  output logic        out_last_o
);

  logic [31:0] pos_q;
  logic [CUR_W-1:0] cur_q;
  logic [31:0] bis_q;
  logic        magic_ok_q;
  logic [31:0] entry_q;
  logic [15:0] phent_q, phnum_q;

  logic        seg_load_q [MAX_SEG];
  logic [31:0] seg_off_q  [MAX_SEG];
  logic [31:0] seg_pa_q   [MAX_SEG];
  logic [31:0] seg_fsz_q  [MAX_SEG];
  logic [31:0] seg_msz_q  [MAX_SEG];

  logic        pend_v_q, out_v_q;
  kind_e       pend_kind_q, out_kind_q;
  logic [31:0] pend_addr_q, out_addr_q;
  logic [7:0]  pend_data_q, out_data_q;
  logic [31:0] pend_len_q, out_len_q;
  logic [1:0]  pend_err_q, out_err_q;
  logic        out_last_q;

  logic [SEG_IW-1:0] idx;
  logic [31:0] pos_inc, bis_inc;
  logic [15:0] cur16, cur16_inc;
  logic        entry_end, out_free;
  logic [31:0] cur_off, cur_pa, cur_fsz, cur_msz;
  logic [31:0] new_addr, new_len;
  logic [7:0]  new_data;
  logic [1:0]  new_err;

  assign idx       = cur_q[SEG_IW-1:0];
  assign pos_inc   = pos_q + 32'd1;
  assign bis_inc   = bis_q + 32'd1;
  assign cur16     = 16'(cur_q);
  assign cur16_inc = cur16 + 16'd1;
  assign entry_end = bis_inc >= {16'd0, phent_q};
  assign cur_off   = seg_off_q[idx];
  assign cur_pa    = seg_pa_q[idx];
  assign cur_fsz   = seg_fsz_q[idx];
  assign cur_msz   = seg_msz_q[idx];
  assign out_free  = !out_v_q || out_tready_i;

  // Status toward the controller
  always_comb begin
    sts_o.magic_ok    = magic_ok_q;
    sts_o.hdr_last    = pos_q == HDR_LAST_POS;
    sts_o.count_big   = phnum_q > 16'(MAX_SEG);
    sts_o.tsize_zero  = (phent_q == 16'd0) || (phnum_q == 16'd0);
    sts_o.cur_end     = cur16 >= phnum_q;
    sts_o.cur_is_load = seg_load_q[idx];
    sts_o.off_lt      = cur_off < pos_q;
    sts_o.off_gt      = cur_off > pos_q;
    sts_o.fsz_zero    = cur_fsz == 32'd0;
    sts_o.tbl_end     = entry_end && (cur16_inc >= phnum_q);
    sts_o.skip_hit    = pos_inc == cur_off;
    sts_o.load_end    = bis_inc >= cur_fsz;
    sts_o.pend_v      = pend_v_q;
    sts_o.out_free    = out_free;
  end

  // Position, segment index and byte-in-entry counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 32'd0;
      cur_q <= '0;
      bis_q <= 32'd0;
    end else begin
      if (cmd_i.hdr_byte || cmd_i.tbl_byte || cmd_i.skip_byte || cmd_i.load_byte) begin
        pos_q <= pos_inc;
      end
      if (cmd_i.init_tbl) begin
        cur_q <= '0;
        bis_q <= 32'd0;
      end else if (cmd_i.tbl_byte) begin
        if (entry_end) begin
          bis_q <= 32'd0;
          cur_q <= sts_o.tbl_end ? '0 : cur_q + CUR_W'(1);
        end else begin
          bis_q <= bis_inc;
        end
      end else begin
        if (cmd_i.seg_inc) cur_q <= cur_q + CUR_W'(1);
        if (cmd_i.bis_clr) bis_q <= 32'd0;
        else if (cmd_i.load_byte) bis_q <= bis_inc;
      end
    end
  end

  // Capture magic check and the header fields that matter
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_byte) begin
      if (pos_q < 32'd4) begin
        magic_ok_q <= ((pos_q == 32'd0) || magic_ok_q) && (rx_byte_i == magic_byte(pos_q[1:0]));
      end
      unique case (pos_q[5:0])
        6'd24:   entry_q[7:0]   <= rx_byte_i;
        6'd25:   entry_q[15:8]  <= rx_byte_i;
        6'd26:   entry_q[23:16] <= rx_byte_i;
        6'd27:   entry_q[31:24] <= rx_byte_i;
        6'd42:   phent_q[7:0]   <= rx_byte_i;
        6'd43:   phent_q[15:8]  <= rx_byte_i;
        6'd44:   phnum_q[7:0]   <= rx_byte_i;
        6'd45:   phnum_q[15:8]  <= rx_byte_i;
        default: ;
      endcase
    end
  end

  // Fill the segment table; a good header drops every load flag, the first byte
  // of an entry sets it when that byte is 1 and clears the entry's other fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_tbl) begin
      for (int unsigned i = 0; i < MAX_SEG; i++) seg_load_q[i] <= 1'b0;
    end else if (cmd_i.tbl_byte && (bis_q < PH_USED_LEN)) begin
      if (bis_q == 32'd0) begin
        seg_load_q[idx] <= rx_byte_i == 8'd1;
        seg_off_q[idx]  <= 32'd0;
        seg_pa_q[idx]   <= 32'd0;
        seg_fsz_q[idx]  <= 32'd0;
        seg_msz_q[idx]  <= 32'd0;
      end else begin
        unique case (bis_q[4:2])
          3'd0: if (rx_byte_i != 8'd0) seg_load_q[idx] <= 1'b0;
          3'd1: seg_off_q[idx][8*bis_q[1:0] +: 8] <= rx_byte_i;
          3'd3: seg_pa_q[idx][8*bis_q[1:0] +: 8]  <= rx_byte_i;
          3'd4: seg_fsz_q[idx][8*bis_q[1:0] +: 8] <= rx_byte_i;
          3'd5: seg_msz_q[idx][8*bis_q[1:0] +: 8] <= rx_byte_i;
          default: ;
        endcase
      end
    end
  end

  // Build the fields of a new result
  always_comb begin
    new_addr = 32'd0;
    new_data = 8'd0;
    new_len  = 32'd0;
    new_err  = 2'd0;
    unique case (cmd_i.push_kind)
      KIND_STORE: begin
        new_addr = cur_pa + bis_q;
        new_data = rx_byte_i;
      end
      KIND_FILL: begin
        new_addr = cur_pa + cur_fsz;
        new_len  = (cur_msz > cur_fsz) ? cur_msz - cur_fsz : 32'd0;
      end
      KIND_DONE:  new_addr = entry_q;
      KIND_ERROR: new_err  = cmd_i.push_err;
      default: ;
    endcase
  end

  // Hold one result back until it is known whether it closes the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if ((cmd_i.push && pend_v_q) || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (out_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.push && pend_v_q) || cmd_i.flush) begin
      out_kind_q <= pend_kind_q;
      out_addr_q <= pend_addr_q;
      out_data_q <= pend_data_q;
      out_len_q  <= pend_len_q;
      out_err_q  <= pend_err_q;
      out_last_q <= cmd_i.flush;
    end
    if (cmd_i.push) begin
      pend_kind_q <= cmd_i.push_kind;
      pend_addr_q <= new_addr;
      pend_data_q <= new_data;
      pend_len_q  <= new_len;
      pend_err_q  <= new_err;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_kind_o  = out_kind_q;
  assign out_addr_o  = out_addr_q;
  assign out_data_o  = out_data_q;
  assign out_len_o   = out_len_q;
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

  `ESL_ASSERT_IMP(a_push_room, cmd_i.push && pend_v_q, out_free)
  `ESL_ASSERT_IMP(a_flush_room, cmd_i.flush, pend_v_q && out_free && !cmd_i.push)
  `ESL_ASSERT_IMP(a_cur_range, 1'b1, cur16 <= 16'(MAX_SEG))
  `ESL_ASSERT_IMP(a_load_nonempty, cmd_i.load_byte, cur_fsz != 32'd0)

endmodule

@@ hw/rtl/esl_ctrl.sv @@
// Controller state machine of the ELF loader: header, table, skip, load, dispatch.
// Depends on esl_pkg; drives esl_dp through cmd_t and reads sts_t.
module esl_ctrl
  import esl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   acc, push_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_HDR;
    else         state_q <= state_d;
  end

  assign push_ok = !sts_i.pend_v || sts_i.out_free;

  // Input is taken in byte states once the previous item's results are handed off
  always_comb begin
    unique case (state_q)
      ST_HDR, ST_TBL, ST_SKIP, ST_LOAD, ST_DONE, ST_ERR: in_ready_o = !sts_i.pend_v;
      default: in_ready_o = 1'b0;
    endcase
  end
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.push_kind = KIND_STORE;
    cmd_o.push_err  = ERR_NONE;
    unique case (state_q)
      ST_HDR, ST_TBL, ST_SKIP, ST_LOAD, ST_DONE, ST_ERR: begin
        // Release the held result as the last of its item
        cmd_o.flush = sts_i.pend_v && sts_i.out_free;
      end
      default: ;
    endcase
    unique case (state_q)
      ST_HDR: begin
        if (acc) begin
          cmd_o.hdr_byte = 1'b1;
          if (sts_i.hdr_last) state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts_i.magic_ok || sts_i.count_big) begin
          if (push_ok) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_kind = KIND_ERROR;
            cmd_o.push_err  = sts_i.magic_ok ? ERR_COUNT : ERR_MAGIC;
            state_d         = ST_ERR;
          end
        end else begin
          cmd_o.init_tbl = 1'b1;
          state_d        = sts_i.tsize_zero ? ST_DISP : ST_TBL;
        end
      end
      ST_TBL: begin
        if (acc) begin
          cmd_o.tbl_byte = 1'b1;
          if (sts_i.tbl_end) state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        // Walk the table one entry per cycle; a push waits while the output is stalled
        priority if (!sts_i.cur_end && !sts_i.cur_is_load) begin
          cmd_o.seg_inc = 1'b1;
        end else if (sts_i.cur_end) begin
          if (push_ok) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_kind = KIND_DONE;
            state_d         = ST_DONE;
          end
        end else if (sts_i.off_lt) begin
          if (push_ok) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_kind = KIND_ERROR;
            cmd_o.push_err  = ERR_BEHIND;
            state_d         = ST_ERR;
          end
        end else if (sts_i.off_gt) begin
          state_d = ST_SKIP;
        end else if (!sts_i.fsz_zero) begin
          cmd_o.bis_clr = 1'b1;
          state_d       = ST_LOAD;
        end else if (push_ok) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_FILL;
          cmd_o.seg_inc   = 1'b1;
        end
      end
      ST_SKIP: begin
        if (acc) begin
          cmd_o.skip_byte = 1'b1;
          if (sts_i.skip_hit) state_d = ST_DISP;
        end
      end
      ST_LOAD: begin
        if (acc) begin
          cmd_o.load_byte = 1'b1;
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_STORE;
          if (sts_i.load_end) state_d = ST_LFILL;
        end
      end
      ST_LFILL: begin
        if (push_ok) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_FILL;
          cmd_o.seg_inc   = 1'b1;
          cmd_o.bis_clr   = 1'b1;
          state_d         = ST_DISP;
        end
      end
      ST_DONE, ST_ERR: ;
      default: state_d = ST_HDR;
    endcase
  end

endmodule

@@ hw/rtl/elf_stream_loader.sv @@
// Top level of the streaming ELF32 program loader.
// Depends on esl_pkg, esl_ctrl and esl_dp.
//
//  channel  | dir | tdata (low bit up)                         | tuser       | tlast
//  s_axis   | in  | rx_byte[7:0]                               | -           | -
//  m_axis   | out | target_address, store_data, fill_length,   | result_kind | last
//           |     | error_code, 6 zero bits (80 bits)          |             |
//
// After a byte with results, the next byte waits until its last result is released.
// The final header byte is followed by a check state, a segment end by its fill
// state, and after a byte the segment table is walked entry by entry in sequence.
// Reset needs no clearing pass. A stalled output holds the walk; one result is
// held back so tlast can mark the final result of each input item.
module elf_stream_loader
  import esl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // target_address, store_data, fill_length, error_code
  output logic [1:0]  m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o
);

  cmd_t        cmd;
  sts_t        sts;
  kind_e       kind;
  logic [31:0] addr, len;
  logic [7:0]  data;
  logic [1:0]  err;

  esl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  esl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rx_byte_i    (s_axis_tdata_i),
    .out_tready_i (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_kind_o   (kind),
    .out_addr_o   (addr),
    .out_data_o   (data),
    .out_len_o    (len),
    .out_err_o    (err),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {6'd0, err, len, data, addr};
  assign m_axis_tuser_o = kind;

endmodule
